// File: src/sialu_pkg.sv
// Shared types and opcodes for the signed integer ALU.
// No dependencies.
package sialu_pkg;
	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;
endpackage

// File: src/sialu_mul.sv
// Pipelined low-half multiplier, split into half-width partial products.
// Depends on nothing; the partial products are registered, then their sum.
module sialu_mul #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic [DATA_WIDTH-1:0] a,
	input  logic [DATA_WIDTH-1:0] b,
	output logic [DATA_WIDTH-1:0] p
);
	localparam int H = DATA_WIDTH / 2;
	localparam int L = DATA_WIDTH - H;

	logic [DATA_WIDTH-1:0] ll_s1, cross_s1;
	logic [DATA_WIDTH-1:0] al, bl, ah, bh;

	assign al = {{H{1'b0}}, a[L-1:0]};
	assign bl = {{H{1'b0}}, b[L-1:0]};
	assign ah = {{L{1'b0}}, a[DATA_WIDTH-1:L]};
	assign bh = {{L{1'b0}}, b[DATA_WIDTH-1:L]};

	// only terms below 2^DATA_WIDTH matter
	always_ff @(posedge clk) begin
		ll_s1    <= al * bl;
		cross_s1 <= ((ah * bl) + (al * bh)) << L;
	end

	always_ff @(posedge clk) begin
		p <= ll_s1 + cross_s1;
	end
endmodule

// File: src/sialu_div.sv
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// Depends on nothing.
module sialu_div #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic [DATA_WIDTH-1:0] n,
	input  logic [DATA_WIDTH-1:0] d,
	output logic [DATA_WIDTH-1:0] q
);
	logic [DATA_WIDTH-1:0] rem_s [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] num_s [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] den_s [DATA_WIDTH+1];

	assign rem_s[0] = '0;
	assign num_s[0] = n;
	assign den_s[0] = d;

	for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_stage
		logic [DATA_WIDTH:0] trial;
		logic [DATA_WIDTH:0] diff;
		assign trial = {rem_s[i], num_s[i][DATA_WIDTH-1]};
		assign diff  = trial - {1'b0, den_s[i]};
		always_ff @(posedge clk) begin
			if (!diff[DATA_WIDTH]) begin
				rem_s[i+1] <= diff[DATA_WIDTH-1:0];
			end else begin
				rem_s[i+1] <= trial[DATA_WIDTH-1:0];
			end
			// quotient bits shift in where numerator bits leave
			num_s[i+1] <= {num_s[i][DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
			den_s[i+1] <= den_s[i];
		end
	end

	assign q = num_s[DATA_WIDTH];
endmodule

// File: src/signed_integer_alu_unit.sv
// Signed integer ALU: add, subtract, multiply, divide.
// Depends on sialu_pkg, sialu_mul, sialu_div.
//
// Usage: drive op, operand_a and operand_b with start high; the item transfers
// on any edge with start high (busy is always low). Exactly one result comes
// back on result_value and divide_by_zero, through stage 1, the divider stages
// and the final stage, marked by done for one cycle; the receiver cannot
// stall. Throughput is one item per cycle; the divider sets the pipeline
// depth, one quotient bit per stage, and all operations share that depth
// so results leave in order. Stage 1 takes operand magnitudes, then the
// divider runs, then a final stage applies sign and selects. Sum and
// difference are formed at entry and delayed. Divide by zero gives 0 with the
// flag set.
// Reset clears the valid line; items in flight are dropped.
module signed_integer_alu_unit
	import sialu_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   op,
	input  logic signed [DATA_WIDTH-1:0] operand_a,
	input  logic signed [DATA_WIDTH-1:0] operand_b,
	output logic                         done,
	output logic signed [DATA_WIDTH-1:0] result_value,
	output logic                         divide_by_zero
);
	localparam int DEPTH = DATA_WIDTH + 1;

	typedef struct packed {
		logic [1:0]            op;
		logic                  neg;
		logic                  dz;
		logic [DATA_WIDTH-1:0] sum;
	} side_t;

	assign busy = 1'b0;

	logic                  v_s1;
	side_t                 side_s1;
	logic [DATA_WIDTH-1:0] mag_a_s1, mag_b_s1, a_s1, b_s1;
	side_t                 ent;

	always_comb begin
		ent.op  = op;
		ent.neg = operand_a[DATA_WIDTH-1] ^ operand_b[DATA_WIDTH-1];
		ent.dz  = (operand_b == '0);
		ent.sum = (op_t'(op) == OP_SUB) ? operand_a - operand_b
		                                : operand_a + operand_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		side_s1  <= ent;
		a_s1     <= operand_a;
		b_s1     <= operand_b;
		mag_a_s1 <= operand_a[DATA_WIDTH-1] ? -operand_a : operand_a;
		mag_b_s1 <= operand_b[DATA_WIDTH-1] ? -operand_b : operand_b;
	end

	logic [DATA_WIDTH-1:0] quo, prod;

	sialu_div #(.DATA_WIDTH(DATA_WIDTH)) u_div (
		.clk(clk), .n(mag_a_s1), .d(mag_b_s1), .q(quo)
	);

	sialu_mul #(.DATA_WIDTH(DATA_WIDTH)) u_mul (
		.clk(clk), .a(a_s1), .b(b_s1), .p(prod)
	);

	// product leaves the multiplier early; delay it to divider latency
	logic [DATA_WIDTH-1:0] prod_dly [DATA_WIDTH-2];
	always_ff @(posedge clk) begin
		prod_dly[0] <= prod;
	end
	for (genvar i = 1; i < DATA_WIDTH - 2; i++) begin : g_pd
		always_ff @(posedge clk) begin
			prod_dly[i] <= prod_dly[i-1];
		end
	end

	logic  v_line    [DEPTH];
	side_t side_line [DEPTH];
	assign v_line[0]    = v_s1;
	assign side_line[0] = side_s1;
	for (genvar i = 1; i < DEPTH; i++) begin : g_line
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_line[i] <= 1'b0;
			end else begin
				v_line[i] <= v_line[i-1];
			end
		end
		always_ff @(posedge clk) begin
			side_line[i] <= side_line[i-1];
		end
	end

	side_t                 sd;
	logic [DATA_WIDTH-1:0] res;
	assign sd = side_line[DEPTH-1];

	always_comb begin
		case (op_t'(sd.op))
			OP_ADD, OP_SUB: res = sd.sum;
			OP_MUL:         res = prod_dly[DATA_WIDTH-3];
			OP_DIV:         res = sd.dz ? '0 : (sd.neg ? -quo : quo);
			default:        res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_line[DEPTH-1];
		end
	end

	always_ff @(posedge clk) begin
		result_value   <= res;
		divide_by_zero <= (op_t'(sd.op) == OP_DIV) && sd.dz;
	end
endmodule
